// ===== sv/psg_pkg.sv =====
package psg_pkg;

    localparam int unsigned COORD_WIDTH_DEF   = 32;
    localparam int unsigned CORDIC_STAGES_DEF = 16;
    localparam int unsigned ZW = 26;
    localparam int unsigned HW = 18;

    localparam logic signed [HW-1:0] HALF_TURN    = 18'sd23040;
    localparam logic signed [HW-1:0] QUARTER_TURN = 18'sd11520;
    localparam logic signed [HW-1:0] FULL_TURN    = 18'sd46080;
    localparam logic signed [ZW-1:0] Z_HALF_TURN  = 26'sd11796480;
    localparam logic [23:0] KINV_Q24 = 24'd10188014;
    localparam logic [24:0] ROT_Q8   = 25'd33043439;

    typedef enum logic [2:0] {
        REG_A_X, REG_A_Y, REG_B_X, REG_B_Y, REG_RADIUS, REG_EXIT, REG_SPEED, REG_MODE
    } cfg_reg_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ZW-1:0] atan_at(input int unsigned i);
        case (i)
            0:  return 26'sd2949120;
            1:  return 26'sd1740967;
            2:  return 26'sd919879;
            3:  return 26'sd466945;
            4:  return 26'sd234379;
            5:  return 26'sd117304;
            6:  return 26'sd58666;
            7:  return 26'sd29335;
            8:  return 26'sd14668;
            9:  return 26'sd7334;
            10: return 26'sd3667;
            11: return 26'sd1833;
            12: return 26'sd917;
            13: return 26'sd458;
            14: return 26'sd229;
            15: return 26'sd115;
            16: return 26'sd57;
            17: return 26'sd29;
            18: return 26'sd14;
            19: return 26'sd7;
            20: return 26'sd4;
            21: return 26'sd2;
            22: return 26'sd1;
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [HW-1:0] wrap_head(input logic signed [HW-1:0] h);
        logic signed [HW-1:0] t;
        t = h;
        if (t > HALF_TURN) t = t - FULL_TURN;
        if (t < -HALF_TURN) t = t + FULL_TURN;
        return t;
    endfunction

endpackage

// ===== sv/path_segment_guidance.sv =====
// Path guidance for one line or arc segment. Each position request yields one
// result; a new request is taken every clock cycle while pos_stall is low. The
// result passes through the entry and prep stages, two rows of CORDIC_STAGES
// vectoring CORDIC cells, the rounding and gain-correction stages and the
// output stage. After any configuration write the turn-rate divider runs and
// pos_stall stays high meanwhile; at other times pos_stall is high only while a
// finished result is held by res_stall.
module path_segment_guidance #(
    parameter int unsigned COORD_WIDTH   = psg_pkg::COORD_WIDTH_DEF,
    parameter int unsigned CORDIC_STAGES = psg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            cfg_valid,
    output logic                                            cfg_ready,
    input  psg_pkg::cfg_reg_t                               cfg_index,
    input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_data,
    input  logic                                            pos_valid,
    output logic                                            pos_stall,
    input  logic signed [COORD_WIDTH-1:0]                   pos_x,
    input  logic signed [COORD_WIDTH-1:0]                   pos_y,
    output logic                                            res_valid,
    input  logic                                            res_stall,
    output logic signed [15:0]                              heading_cmd,
    output logic signed [31:0]                              cross_track,
    output logic [15:0]                                     speed_cmd,
    output logic signed [31:0]                              turn_rate_cmd,
    output logic                                            advance
);
    import psg_pkg::*;

    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned DF = W + 1;
    localparam int unsigned SW = W + 2;
    localparam int unsigned CW = (W + 4 > 26) ? W + 4 : 26;
    localparam int unsigned S  = CORDIC_STAGES;
    localparam int unsigned XW = ((CW > 32) ? CW : 32) + 2;

    // configuration
    logic signed [W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [30:0]         radius_reg;
    logic signed [15:0]  exit_reg;
    logic [15:0]         speed_reg;
    logic [1:0]          mode_reg;
    logic                is_arc, is_left;

    assign cfg_ready = 1'b1;
    assign is_arc    = mode_reg[0];
    assign is_left   = mode_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg     <= '0;
            ay_reg     <= '0;
            bx_reg     <= '0;
            by_reg     <= '0;
            radius_reg <= '0;
            exit_reg   <= '0;
            speed_reg  <= '0;
            mode_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_A_X:    ax_reg     <= cfg_data[W-1:0];
                REG_A_Y:    ay_reg     <= cfg_data[W-1:0];
                REG_B_X:    bx_reg     <= cfg_data[W-1:0];
                REG_B_Y:    by_reg     <= cfg_data[W-1:0];
                REG_RADIUS: radius_reg <= cfg_data[30:0];
                REG_EXIT:   exit_reg   <= cfg_data[15:0];
                REG_SPEED:  speed_reg  <= cfg_data[15:0];
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    logic        div_busy;
    logic [30:0] rate;

    psg_rate_div u_rate_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_valid),
        .speed  (speed_reg),
        .radius (radius_reg),
        .busy   (div_busy),
        .rate   (rate)
    );

    // pipeline control
    logic en, accept;
    logic res_valid_reg;

    assign en        = !(res_valid_reg && res_stall);
    assign pos_stall = div_busy || !en;
    assign accept    = pos_valid && !pos_stall;

    logic vld_e_reg, vld_1_reg, vld_2_reg;
    logic vld_d [0:S];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg     <= 1'b0;
            vld_1_reg     <= 1'b0;
            vld_2_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k <= S; k++)
                vld_d[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_e_reg <= accept;
            vld_d[0]  <= vld_e_reg;
            for (int k = 1; k <= S; k++)
                vld_d[k] <= vld_d[k-1];
            vld_1_reg     <= vld_d[S];
            vld_2_reg     <= vld_1_reg;
            res_valid_reg <= vld_2_reg;
        end
    end

    // entry stage: vectors for both cordic rows
    logic signed [DF-1:0] pxe, pye, axe, aye, bxe, bye;
    logic signed [DF-1:0] n1_reg, e1_reg, qa_reg, qb_reg, n2_reg, e2_reg;

    assign pxe = DF'(pos_x);
    assign pye = DF'(pos_y);
    assign axe = DF'(ax_reg);
    assign aye = DF'(ay_reg);
    assign bxe = DF'(bx_reg);
    assign bye = DF'(by_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg <= is_arc ? pye - aye : bye - aye;
            e1_reg <= is_arc ? pxe - axe : bxe - axe;
            qa_reg <= is_arc ? '0 : pye - bye;
            qb_reg <= is_arc ? '0 : pxe - bxe;
            n2_reg <= bye - pye;
            e2_reg <= bxe - pxe;
        end
    end

    // prep stage: half-plane fold and axis-aligned shortcuts
    logic signed [CW-1:0] px1_next, py1_next, pa1_next, pb1_next, px2_next, py2_next;
    logic signed [ZW-1:0] pz1_next, pz2_next;
    logic signed [CW-1:0] px1_reg, py1_reg, pa1_reg, pb1_reg, px2_reg, py2_reg;
    logic signed [ZW-1:0] pz1_reg, pz2_reg;
    logic                 sp1_next, sp2_next;
    logic signed [HW-1:0] sh1_next, sh2_next;
    logic signed [SW-1:0] slen, sxtk, spv_next;

    always_comb
    begin
        px1_next = CW'(n1_reg);
        py1_next = CW'(e1_reg);
        pa1_next = CW'(qa_reg);
        pb1_next = CW'(qb_reg);
        pz1_next = '0;
        if (n1_reg < 0)
        begin
            px1_next = -px1_next;
            py1_next = -py1_next;
            pa1_next = -pa1_next;
            pb1_next = -pb1_next;
            pz1_next = (e1_reg >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
        end
        px2_next = CW'(n2_reg);
        py2_next = CW'(e2_reg);
        pz2_next = '0;
        if (n2_reg < 0)
        begin
            px2_next = -px2_next;
            py2_next = -py2_next;
            pz2_next = (e2_reg >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
        end

        sp1_next = (e1_reg == '0) || (n1_reg == '0);
        if (e1_reg == '0)
            sh1_next = (n1_reg > 0) ? 18'sd0 : HALF_TURN;
        else
            sh1_next = (e1_reg > 0) ? QUARTER_TURN : -QUARTER_TURN;
        sp2_next = (e2_reg == '0) || (n2_reg == '0);
        if (e2_reg == '0)
            sh2_next = (n2_reg > 0) ? 18'sd0 : HALF_TURN;
        else
            sh2_next = (e2_reg > 0) ? QUARTER_TURN : -QUARTER_TURN;

        if (e1_reg == '0)
            slen = (n1_reg < 0) ? -SW'(n1_reg) : SW'(n1_reg);
        else
            slen = (e1_reg < 0) ? -SW'(e1_reg) : SW'(e1_reg);

        // exact offset from an axis-aligned line
        if (e1_reg == '0 && n1_reg == '0)
            sxtk = '0;
        else if (e1_reg == '0)
            sxtk = (n1_reg > 0) ? SW'(qb_reg) : -SW'(qb_reg);
        else
            sxtk = (e1_reg > 0) ? -SW'(qa_reg) : SW'(qa_reg);
        spv_next = is_arc ? slen : sxtk;
    end

    logic                 sp1_d [0:S];
    logic                 sp2_d [0:S];
    logic signed [HW-1:0] sh1_d [0:S];
    logic signed [HW-1:0] sh2_d [0:S];
    logic signed [SW-1:0] spv_d [0:S];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg  <= px1_next;
            py1_reg  <= py1_next;
            pa1_reg  <= pa1_next;
            pb1_reg  <= pb1_next;
            pz1_reg  <= pz1_next;
            px2_reg  <= px2_next;
            py2_reg  <= py2_next;
            pz2_reg  <= pz2_next;
            sp1_d[0] <= sp1_next;
            sp2_d[0] <= sp2_next;
            sh1_d[0] <= sh1_next;
            sh2_d[0] <= sh2_next;
            spv_d[0] <= spv_next;
            for (int k = 1; k <= S; k++)
            begin
                sp1_d[k] <= sp1_d[k-1];
                sp2_d[k] <= sp2_d[k-1];
                sh1_d[k] <= sh1_d[k-1];
                sh2_d[k] <= sh2_d[k-1];
                spv_d[k] <= spv_d[k-1];
            end
        end
    end

    // two rows of cordic cells
    logic signed [CW-1:0] c1x [0:S];
    logic signed [CW-1:0] c1y [0:S];
    logic signed [CW-1:0] c1a [0:S];
    logic signed [CW-1:0] c1b [0:S];
    logic signed [ZW-1:0] c1z [0:S];
    logic signed [CW-1:0] c2x [0:S];
    logic signed [CW-1:0] c2y [0:S];
    logic signed [CW-1:0] c2a [0:S];
    logic signed [CW-1:0] c2b [0:S];
    logic signed [ZW-1:0] c2z [0:S];

    assign c1x[0] = px1_reg;
    assign c1y[0] = py1_reg;
    assign c1a[0] = pa1_reg;
    assign c1b[0] = pb1_reg;
    assign c1z[0] = pz1_reg;
    assign c2x[0] = px2_reg;
    assign c2y[0] = py2_reg;
    assign c2a[0] = '0;
    assign c2b[0] = '0;
    assign c2z[0] = pz2_reg;

    for (genvar k = 0; k < S; k++)
    begin : g_cell
        psg_cell #(.CW(CW), .IDX(k)) u_row1 (
            .clk   (clk),
            .en    (en),
            .x_in  (c1x[k]),
            .y_in  (c1y[k]),
            .a_in  (c1a[k]),
            .b_in  (c1b[k]),
            .z_in  (c1z[k]),
            .x_out (c1x[k+1]),
            .y_out (c1y[k+1]),
            .a_out (c1a[k+1]),
            .b_out (c1b[k+1]),
            .z_out (c1z[k+1])
        );
        psg_cell #(.CW(CW), .IDX(k)) u_row2 (
            .clk   (clk),
            .en    (en),
            .x_in  (c2x[k]),
            .y_in  (c2y[k]),
            .a_in  (c2a[k]),
            .b_in  (c2b[k]),
            .z_in  (c2z[k]),
            .x_out (c2x[k+1]),
            .y_out (c2y[k+1]),
            .a_out (c2a[k+1]),
            .b_out (c2b[k+1]),
            .z_out (c2z[k+1])
        );
    end

    // post stage 1: angle rounding, magnitude select
    logic signed [ZW:0]   zr1, zr2, zs1, zs2;
    logic signed [CW-1:0] msrc;
    logic signed [HW-1:0] head1_reg, head2_reg;
    logic [CW-1:0]        mag_reg;
    logic                 neg1_reg, sp1_reg;
    logic signed [SW-1:0] spv1_reg;

    always_comb
    begin
        zr1  = (ZW+1)'(c1z[S]) + 27'sd256;
        zr2  = (ZW+1)'(c2z[S]) + 27'sd256;
        zs1  = zr1 >>> 9;
        zs2  = zr2 >>> 9;
        msrc = is_arc ? c1x[S] : c1b[S];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head1_reg <= sp1_d[S] ? sh1_d[S] : wrap_head(zs1[HW-1:0]);
            head2_reg <= sp2_d[S] ? sh2_d[S] : wrap_head(zs2[HW-1:0]);
            neg1_reg  <= msrc[CW-1];
            mag_reg   <= msrc[CW-1] ? CW'(-msrc) : CW'(msrc);
            sp1_reg   <= sp1_d[S];
            spv1_reg  <= spv_d[S];
        end
    end

    // post stage 2: gain correction products, heading, line advance
    logic [CW-1:0]        hi_reg;
    logic [47:0]          lo_reg;
    logic signed [HW-1:0] head_reg, turn_ang;
    logic                 adv_line_reg, neg2_reg, sp2_reg;
    logic signed [SW-1:0] spv2_reg;

    assign turn_ang = wrap_head(head1_reg - head2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg <= CW'(mag_reg[CW-1:24]) * CW'(KINV_Q24);
            lo_reg <= 48'(mag_reg[23:0]) * 48'(KINV_Q24);
            if (is_arc)
                head_reg <= wrap_head(head1_reg + (is_left ? QUARTER_TURN : -QUARTER_TURN));
            else
                head_reg <= head1_reg;
            adv_line_reg <= (turn_ang > QUARTER_TURN) || (turn_ang < -QUARTER_TURN);
            neg2_reg     <= neg1_reg;
            sp2_reg      <= sp1_reg;
            spv2_reg     <= spv1_reg;
        end
    end

    // output stage
    logic [CW:0]          umag;
    logic signed [XW-1:0] smag, arc_dist, xtk;
    logic signed [HW-1:0] exit_turn;
    logic signed [31:0]   xtk_sat;
    logic signed [31:0]   rate_next;
    logic                 adv_next;

    always_comb
    begin
        umag = (CW+1)'(hi_reg) + (CW+1)'((lo_reg + 48'h800000) >> 24);
        smag = neg2_reg ? -XW'(umag) : XW'(umag);
        arc_dist = sp2_reg ? XW'(spv2_reg) : XW'(umag);
        if (is_arc)
            xtk = is_left ? arc_dist - XW'(radius_reg) : XW'(radius_reg) - arc_dist;
        else
            xtk = sp2_reg ? XW'(spv2_reg) : smag;
        if (xtk > $signed(XW'(32'h7fffffff)))
            xtk_sat = 32'sh7fffffff;
        else if (xtk < -$signed(XW'(33'h080000000)))
            xtk_sat = 32'sh80000000;
        else
            xtk_sat = xtk[31:0];

        exit_turn = wrap_head(HW'(exit_reg) - head_reg);
        if (is_arc)
            adv_next = exit_turn[HW-1] ? !is_left : is_left;
        else
            adv_next = adv_line_reg;

        if (!is_arc)
            rate_next = '0;
        else if (is_left)
            rate_next = -$signed({1'b0, rate});
        else
            rate_next = $signed({1'b0, rate});
    end

    logic signed [15:0] head_out_reg;
    logic signed [31:0] xtk_out_reg, rate_out_reg;
    logic [15:0]        speed_out_reg;
    logic               adv_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_out_reg  <= head_reg[15:0];
            xtk_out_reg   <= xtk_sat;
            rate_out_reg  <= rate_next;
            speed_out_reg <= speed_reg;
            adv_out_reg   <= adv_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign heading_cmd   = head_out_reg;
    assign cross_track   = xtk_out_reg;
    assign speed_cmd     = speed_out_reg;
    assign turn_rate_cmd = rate_out_reg;
    assign advance       = adv_out_reg;

endmodule

// ===== sv/psg_cell.sv =====
module psg_cell #(
    parameter int unsigned CW  = 36,
    parameter int unsigned IDX = 0
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [CW-1:0]           x_in,
    input  logic signed [CW-1:0]           y_in,
    input  logic signed [CW-1:0]           a_in,
    input  logic signed [CW-1:0]           b_in,
    input  logic signed [psg_pkg::ZW-1:0]  z_in,
    output logic signed [CW-1:0]           x_out,
    output logic signed [CW-1:0]           y_out,
    output logic signed [CW-1:0]           a_out,
    output logic signed [CW-1:0]           b_out,
    output logic signed [psg_pkg::ZW-1:0]  z_out
);
    import psg_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_at(IDX);

    logic signed [CW-1:0] x_reg, y_reg, a_reg, b_reg;
    logic signed [CW-1:0] x_next, y_next, a_next, b_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [CW-1:0] xs, ys, as2, bs;

    always_comb
    begin
        xs  = x_in >>> IDX;
        ys  = y_in >>> IDX;
        as2 = a_in >>> IDX;
        bs  = b_in >>> IDX;
        // rotate toward y = 0, companion follows the same rotation
        if (!y_in[CW-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            a_next = a_in + bs;
            b_next = b_in - as2;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            a_next = a_in - bs;
            b_next = b_in + as2;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            a_reg <= a_next;
            b_reg <= b_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign a_out = a_reg;
    assign b_out = b_reg;
    assign z_out = z_reg;

endmodule

// ===== sv/psg_rate_div.sv =====
module psg_rate_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] speed,
    input  logic [30:0] radius,
    output logic        busy,
    output logic [30:0] rate
);
    import psg_pkg::*;

    localparam logic [5:0] CNT_IDLE = 6'd0;
    localparam logic [5:0] CNT_MUL  = 6'd34;
    localparam logic [5:0] CNT_LOAD = 6'd33;
    localparam logic [5:0] CNT_TOP  = 6'd32;

    logic [5:0]  cnt_reg;
    logic        sat_reg;
    logic [40:0] prod_reg;
    logic [41:0] rem_reg;
    logic [69:0] dvs_reg;
    logic [30:0] quo_reg;
    logic        ge;

    assign ge = {28'b0, rem_reg} >= dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_IDLE;
            sat_reg <= 1'b1;
        end
        else
        begin
            if (start)
                cnt_reg <= CNT_MUL;
            else if (cnt_reg != CNT_IDLE)
                cnt_reg <= cnt_reg - 6'd1;
            // quotient of 2^31 or more saturates, zero radius lands here too
            if (!start && cnt_reg == CNT_TOP)
                sat_reg <= ge;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_reg == CNT_MUL)
            prod_reg <= 41'(speed) * 41'(ROT_Q8);
        else if (cnt_reg == CNT_LOAD)
        begin
            rem_reg <= 42'(prod_reg) + 42'({radius, 7'b0});
            dvs_reg <= {radius, 39'b0};
        end
        else if (cnt_reg == CNT_TOP)
            dvs_reg <= dvs_reg >> 1;
        else if (cnt_reg != CNT_IDLE)
        begin
            if (ge)
                rem_reg <= rem_reg - dvs_reg[41:0];
            quo_reg <= {quo_reg[29:0], ge};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    assign busy = (cnt_reg != CNT_IDLE);
    assign rate = sat_reg ? 31'h7fffffff : quo_reg;

endmodule
